// ===== rtl/core/issr_pkg.sv =====
// Shared types and codes for the indexed set with swap-remove.
package issr_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] occupancy;
  } rsp_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        cmp_en;
    logic [31:0] cmp_key;
    logic        add_en;
    logic [31:0] add_key;
    logic        rem_en;
    logic [31:0] last_key;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/issr_cell.sv =====
// One storage cell: key, occupied flag and compare result.
module issr_cell (
  input  logic                clk,
  input  logic                rst,
  input  issr_pkg::cell_ctrl_t ctrl,
  input  logic                occ_prev,
  input  logic                occ_next,
  output logic                occ,
  output logic                is_last,
  output logic                match,
  output logic [31:0]         key
);

  logic first_free;

  assign is_last    = occ && !occ_next;
  assign first_free = !occ && occ_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        match <= occ && (key == ctrl.cmp_key);
      end
      if (ctrl.add_en && first_free) begin
        occ <= 1'b1;
      end else if (ctrl.rem_en && is_last) begin
        occ <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.add_en && first_free) begin
      key <= ctrl.add_key;
    end else if (ctrl.rem_en && match && !is_last) begin
      // fill the hole with the last key
      key <= ctrl.last_key;
    end
  end

endmodule

// ===== rtl/core/indexed_set_swap_remove.sv =====
// Top level: a row of key cells with a compare/update controller.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------
//   request | req_valid | req_stall | req (mode, key)
//   result  | rsp_valid | rsp_stall | rsp (status, position, occupancy)
//
// All cells compare the key as the request is accepted; in the compare state
// the position and last key are gathered and the cells update.
// One request is in the cells at a time; a new request is taken while the
// previous result waits in the output register.
// rst clears the occupied flags and the count; stored keys need no clearing.
// A stalled result holds the compare state until the output register frees.
module indexed_set_swap_remove #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  issr_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output issr_pkg::rsp_t rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CMP  = 2'b10
  } state_t;

  state_t               state, state_next;
  issr_pkg::req_t       req_q;
  logic [CW-1:0]        cnt, cnt_next;
  issr_pkg::cell_ctrl_t ctrl;
  logic [CAPACITY-1:0]  occ, is_last, match;
  logic [31:0]          key_arr [CAPACITY];
  logic [CAPACITY+1:0]  occ_chain;
  logic                 accept, fire, found, full;
  logic [IW-1:0]        found_pos;
  logic [31:0]          last_key;
  issr_pkg::rsp_t       rsp_next;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign fire      = (state == S_CMP) && (!rsp_valid || !rsp_stall);

  // occupied thermometer passed between neighbors
  assign occ_chain[0]          = 1'b1;
  assign occ_chain[CAPACITY+1] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ_chain[i+1] = occ[i];
    issr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .occ_prev (occ_chain[i]),
      .occ_next (occ_chain[i+2]),
      .occ      (occ[i]),
      .is_last  (is_last[i]),
      .match    (match[i]),
      .key      (key_arr[i])
    );
  end

  always_comb begin
    found_pos = '0;
    last_key  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) found_pos = found_pos | IW'(i);
      if (is_last[i]) last_key = last_key | key_arr[i];
    end
  end

  assign found = |match;
  assign full  = (cnt == CW'(CAPACITY));

  always_comb begin
    rsp_next      = '0;
    cnt_next      = cnt;
    ctrl.cmp_en   = accept;
    ctrl.cmp_key  = req.key;
    ctrl.add_en   = 1'b0;
    ctrl.add_key  = req_q.key;
    ctrl.rem_en   = 1'b0;
    ctrl.last_key = last_key;
    case (req_q.mode)
      issr_pkg::MODE_ADD: begin
        if (found) begin
          rsp_next.status   = issr_pkg::ST_DUP;
          rsp_next.position = 4'(found_pos);
        end else if (full) begin
          rsp_next.status = issr_pkg::ST_FULL;
        end else begin
          rsp_next.status   = issr_pkg::ST_DONE;
          rsp_next.position = 4'(cnt);
          cnt_next          = cnt + CW'(1);
          ctrl.add_en       = fire;
        end
      end
      issr_pkg::MODE_REMOVE: begin
        if (found) begin
          rsp_next.status   = issr_pkg::ST_DONE;
          rsp_next.position = 4'(found_pos);
          cnt_next          = cnt - CW'(1);
          ctrl.rem_en       = fire;
        end else begin
          rsp_next.status = issr_pkg::ST_ABSENT;
        end
      end
      default: begin
        // search; the unused code decodes the same way
        if (found) begin
          rsp_next.status   = issr_pkg::ST_DONE;
          rsp_next.position = 4'(found_pos);
        end else begin
          rsp_next.status = issr_pkg::ST_ABSENT;
        end
      end
    endcase
    rsp_next.occupancy = 5'(cnt_next);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_CMP;
      S_CMP:   if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_q <= req;
    if (fire) rsp <= rsp_next;
  end

`ifndef SYNTHESIS
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $onehot0(match))
    else $error("more than one cell matched the key");

  a_count_occ: assert property (@(posedge clk) disable iff (rst)
    CW'($countones(occ)) == cnt)
    else $error("count disagrees with occupied cells");

  a_accept_cmp: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_CMP)
    else $error("accepted request did not reach compare");

  a_fire_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid && state == S_IDLE)
    else $error("result not presented after update");
`endif

endmodule
